[hw/rtl/stq_pkg.sv]
// types and constants shared by the sorted timer event queue
package stq_pkg;

	localparam int unsigned DEADLINE_W  = 64;
	localparam int unsigned TAG_W       = 16;
	localparam int unsigned DELAY_W     = 32;
	localparam int unsigned MAX_RESULTS = 16;
	localparam int unsigned FIRE_CNT_W  = $clog2(MAX_RESULTS);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_CANCEL = 2'd1,
		OP_TICK   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		KIND_INSERTED  = 3'd0,
		KIND_FULL      = 3'd1,
		KIND_CANCELLED = 3'd2,
		KIND_MISS      = 3'd3,
		KIND_FIRED     = 3'd4,
		KIND_IDLE      = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		CMD_HOLD   = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_CANCEL = 2'd2,
		CMD_POP    = 2'd3
	} cell_cmd_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_FIRE = 1'b1
	} state_t;

	typedef struct packed {
		logic                  valid;
		logic [DEADLINE_W-1:0] deadline;
		logic [TAG_W-1:0]      tag;
	} entry_t;

	typedef struct packed {
		cell_cmd_t             cmd;
		logic [DEADLINE_W-1:0] due;
		logic [TAG_W-1:0]      tag;
	} cell_ctrl_t;

endpackage

[hw/rtl/stq_cell.sv]
// one slot of the sorted event chain
module stq_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  stq_pkg::cell_ctrl_t ctrl,
	input  stq_pkg::entry_t     left_ent,
	input  logic                left_keep,
	input  logic                left_hit,
	input  stq_pkg::entry_t     right_ent,
	output stq_pkg::entry_t     ent,
	output logic                keep,
	output logic                hit
);
	import stq_pkg::*;

	logic   valid_q;
	logic [DEADLINE_W-1:0] deadline_q;
	logic [TAG_W-1:0]      tag_q;
	entry_t cur;
	entry_t nxt;

	assign cur  = '{valid: valid_q, deadline: deadline_q, tag: tag_q};
	assign ent  = cur;
	assign keep = valid_q && (deadline_q <= ctrl.due);
	assign hit  = left_hit || (valid_q && (tag_q == ctrl.tag));

	always_comb begin
		nxt = cur;
		case (ctrl.cmd)
			CMD_INSERT: begin
				if (!keep) begin
					if (left_keep) begin
						nxt = '{valid: 1'b1, deadline: ctrl.due, tag: ctrl.tag};
					end else begin
						nxt = left_ent;
					end
				end
			end
			CMD_CANCEL: begin
				if (hit) begin
					nxt = right_ent;
				end
			end
			CMD_POP: begin
				nxt = right_ent;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		deadline_q <= nxt.deadline;
		tag_q      <= nxt.tag;
	end

endmodule

[hw/rtl/sorted_timer_event_queue.sv]
// sorted timer event queue: top level with tick counter, sequencer and cell chain
// insert and cancel: one result each, a new transaction every cycle unless stalled
// tick: counter +1, then one result per cycle from the head cell unless stalled
// (up to 16 fired events, or one idle result); the chain shifts once per fired event
// output register parts the two sides; the chain takes no transaction while a tick drains
// reset clears the counter, all slot valid bits and the output valid flag
module sorted_timer_event_queue #(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [31:0] delay_ticks,
	input  logic [15:0] event_tag,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  result_kind,
	output logic [15:0] result_tag,
	output logic [63:0] current_time,
	output logic        last_result
);
	import stq_pkg::*;

	state_t                state_q;
	state_t                state_nxt;
	logic [DEADLINE_W-1:0] now_q;
	logic [FIRE_CNT_W-1:0] fire_cnt_q;
	logic                  out_valid_q;
	kind_t                 kind_q;
	logic [TAG_W-1:0]      tag_q;
	logic                  last_q;

	op_t        op;
	logic       acc;
	logic       slot_free;
	logic       full;
	logic       found;
	logic       head_due;
	logic       next_due;
	logic       fire_last;
	logic       emit_en;
	kind_t      emit_kind;
	logic [TAG_W-1:0] emit_tag;
	logic       emit_last;
	cell_ctrl_t ctrl;

	entry_t ent       [QUEUE_DEPTH];
	entry_t left_ent  [QUEUE_DEPTH];
	entry_t right_ent [QUEUE_DEPTH];
	logic   keep      [QUEUE_DEPTH];
	logic   hit       [QUEUE_DEPTH];
	logic   left_keep [QUEUE_DEPTH];
	logic   left_hit  [QUEUE_DEPTH];

	// cell chain
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign left_ent[i]  = '0;
			assign left_keep[i] = 1'b1;
			assign left_hit[i]  = 1'b0;
		end else begin : g_mid
			assign left_ent[i]  = ent[i-1];
			assign left_keep[i] = keep[i-1];
			assign left_hit[i]  = hit[i-1];
		end
		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_ent[i] = '0;
		end else begin : g_inner
			assign right_ent[i] = ent[i+1];
		end

		stq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.left_ent  (left_ent[i]),
			.left_keep (left_keep[i]),
			.left_hit  (left_hit[i]),
			.right_ent (right_ent[i]),
			.ent       (ent[i]),
			.keep      (keep[i]),
			.hit       (hit[i])
		);
	end

	assign op        = op_t'(operation);
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && slot_free;
	assign acc       = in_valid && in_ready;
	assign full      = ent[QUEUE_DEPTH-1].valid;
	assign found     = hit[QUEUE_DEPTH-1];
	assign head_due  = ent[0].valid && (ent[0].deadline <= now_q);
	assign next_due  = ent[1].valid && (ent[1].deadline <= now_q);
	assign fire_last = (fire_cnt_q == FIRE_CNT_W'(MAX_RESULTS - 1)) || !next_due;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc && (op == OP_TICK)) begin
					state_nxt = ST_FIRE;
				end
			end
			ST_FIRE: begin
				if (slot_free && (!head_due || fire_last)) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		emit_en   = 1'b0;
		emit_kind = KIND_IDLE;
		emit_tag  = '0;
		emit_last = 1'b1;
		ctrl.cmd  = CMD_HOLD;
		ctrl.due  = now_q + DEADLINE_W'(delay_ticks);
		ctrl.tag  = event_tag;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					case (op)
						OP_INSERT: begin
							emit_en = 1'b1;
							if (full) begin
								emit_kind = KIND_FULL;
							end else begin
								emit_kind = KIND_INSERTED;
								emit_tag  = event_tag;
								ctrl.cmd  = CMD_INSERT;
							end
						end
						OP_CANCEL: begin
							emit_en  = 1'b1;
							ctrl.cmd = CMD_CANCEL;
							if (found) begin
								emit_kind = KIND_CANCELLED;
								emit_tag  = event_tag;
							end else begin
								emit_kind = KIND_MISS;
							end
						end
						default: begin
							emit_en = 1'b0;
						end
					endcase
				end
			end
			ST_FIRE: begin
				if (slot_free) begin
					emit_en = 1'b1;
					if (head_due) begin
						emit_kind = KIND_FIRED;
						emit_tag  = ent[0].tag;
						emit_last = fire_last;
						ctrl.cmd  = CMD_POP;
					end
				end
			end
			default: begin
				emit_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			now_q       <= '0;
			fire_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (acc && (op == OP_TICK)) begin
				now_q      <= now_q + DEADLINE_W'(1);
				fire_cnt_q <= '0;
			end else if (ctrl.cmd == CMD_POP) begin
				fire_cnt_q <= fire_cnt_q + FIRE_CNT_W'(1);
			end
			if (emit_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (emit_en) begin
			kind_q <= emit_kind;
			tag_q  <= emit_tag;
			last_q <= emit_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = kind_q;
	assign result_tag   = tag_q;
	assign current_time = now_q;
	assign last_result  = last_q;

endmodule

[sim/stq_checker.sv]
// checker for the sorted timer event queue: predicts the results of each transaction and compares
`timescale 1ns / 100ps

module stq_checker #(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [31:0] delay_ticks,
	input  logic [15:0] event_tag,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  result_kind,
	input  logic [15:0] result_tag,
	input  logic [63:0] current_time,
	input  logic        last_result,
	output int          fail_count,
	output int          results_due
);
	import stq_pkg::*;

	typedef struct {
		kind_t       kind;
		logic [15:0] tag;
		logic [63:0] stamp;
		logic        last;
	} timer_result_t;

	timer_result_t expected_results[$];

	logic [63:0] now_ticks;
	logic [63:0] slot_due[QUEUE_DEPTH];
	logic [15:0] slot_tag[QUEUE_DEPTH];
	int unsigned slot_used;
	int          fail_tally = 0;

	assign fail_count = fail_tally;

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		fail_tally++;
	endtask

	task automatic push_result(input kind_t kind, input logic [15:0] tg, input logic last);
		timer_result_t res;
		res.kind  = kind;
		res.tag   = tg;
		res.stamp = now_ticks;
		res.last  = last;
		expected_results.insert(expected_results.size(), res);
	endtask

	task automatic drop_slot(input int unsigned pos);
		int unsigned i;
		for (i = pos; i + 1 < slot_used; i++) begin
			slot_due[i] = slot_due[i + 1];
			slot_tag[i] = slot_tag[i + 1];
		end
		slot_used--;
	endtask

	task automatic apply_operation(input op_t op, input logic [31:0] dly, input logic [15:0] tg);
		logic [63:0] due;
		int unsigned pos;
		int unsigned i;
		int unsigned fired;
		case (op)
			OP_INSERT: begin
				if (slot_used >= QUEUE_DEPTH) begin
					push_result(KIND_FULL, '0, 1'b1);
				end else begin
					due = now_ticks + 64'(dly);
					pos = 0;
					while (pos < slot_used && slot_due[pos] <= due)
						pos++;
					for (i = slot_used; i > pos; i--) begin
						slot_due[i] = slot_due[i - 1];
						slot_tag[i] = slot_tag[i - 1];
					end
					slot_due[pos] = due;
					slot_tag[pos] = tg;
					slot_used++;
					push_result(KIND_INSERTED, tg, 1'b1);
				end
			end
			OP_CANCEL: begin
				pos = 0;
				while (pos < slot_used && slot_tag[pos] != tg)
					pos++;
				if (pos < slot_used) begin
					drop_slot(pos);
					push_result(KIND_CANCELLED, tg, 1'b1);
				end else begin
					push_result(KIND_MISS, '0, 1'b1);
				end
			end
			OP_TICK: begin
				now_ticks = now_ticks + 64'd1;
				fired = 0;
				while (fired < MAX_RESULTS && slot_used > 0 && slot_due[0] <= now_ticks) begin
					push_result(KIND_FIRED, slot_tag[0], 1'b0);
					drop_slot(0);
					fired++;
				end
				if (fired == 0)
					push_result(KIND_IDLE, '0, 1'b1);
				else
					expected_results[expected_results.size() - 1].last = 1'b1;
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		timer_result_t exp_res;
		if (!arst_n) begin
			now_ticks = '0;
			slot_used = 0;
			expected_results.delete();
			results_due <= 0;
		end else begin
			if (in_valid && in_ready)
				apply_operation(op_t'(operation), delay_ticks, event_tag);
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result kind %0d tag %h time %0d",
						result_kind, result_tag, current_time));
				end else begin
					exp_res = expected_results.pop_front();
					if (result_kind != exp_res.kind)
						report_mismatch($sformatf("result_kind %0d, expected %s",
							result_kind, exp_res.kind.name()));
					if (result_tag != exp_res.tag)
						report_mismatch($sformatf("result_tag %h, expected %h",
							result_tag, exp_res.tag));
					if (current_time != exp_res.stamp)
						report_mismatch($sformatf("current_time %0d, expected %0d",
							current_time, exp_res.stamp));
					if (last_result != exp_res.last)
						report_mismatch($sformatf("last_result %b, expected %b",
							last_result, exp_res.last));
				end
			end
			results_due <= expected_results.size();
		end
	end

endmodule

[sim/tb.sv]
// testbench top for the sorted timer event queue: stimulus, flow control and verdict
`timescale 1ns / 100ps

module tb;
	import stq_pkg::*;

	localparam int unsigned QUEUE_DEPTH    = 16;
	localparam int          WATCHDOG_LIMIT = 2000;
	localparam int          RX_STALL_LEN   = 80;
	localparam int          TAIL_CYCLES    = 40;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [1:0]  operation = '0;
	logic [31:0] delay_ticks = '0;
	logic [15:0] event_tag = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  result_kind;
	logic [15:0] result_tag;
	logic [63:0] current_time;
	logic        last_result;

	int fail_count;
	int results_due;
	int tx_idle_pct = 30;
	int rx_idle_pct = 84;
	int idle_cycles = 0;
	bit stall_rx = 1'b0;

	sorted_timer_event_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.delay_ticks(delay_ticks),
		.event_tag(event_tag),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_kind(result_kind),
		.result_tag(result_tag),
		.current_time(current_time),
		.last_result(last_result)
	);

	stq_checker #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.delay_ticks(delay_ticks),
		.event_tag(event_tag),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_kind(result_kind),
		.result_tag(result_tag),
		.current_time(current_time),
		.last_result(last_result),
		.fail_count(fail_count),
		.results_due(results_due)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver side, with an occasional long hold-off
	initial begin
		forever begin
			@(negedge clk);
			if (stall_rx) begin
				out_ready <= 1'b0;
				repeat (RX_STALL_LEN) @(negedge clk);
				stall_rx = 1'b0;
			end
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// entered and left at a falling edge
	task automatic send_item(input op_t op, input logic [31:0] dly, input logic [15:0] tg);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		operation   <= op;
		delay_ticks <= dly;
		event_tag   <= tg;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (results_due != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic run_random(input int n_items, input int stall_at);
		int done;
		int r;
		op_t op;
		logic [31:0] dly;
		logic [15:0] tg;
		done = 0;
		while (done < n_items) begin
			r   = $urandom_range(99);
			dly = $urandom();
			tg  = ($urandom_range(7) == 0) ? 16'($urandom()) : 16'($urandom_range(15));
			if (r < 4) begin
				op = OP_NONE;
			end else if (r < 50) begin
				op = OP_INSERT;
				if ($urandom_range(24) != 0)
					dly = 32'($urandom_range(24));
			end else if (r < 70) begin
				op = OP_CANCEL;
			end else begin
				op = OP_TICK;
			end
			send_item(op, dly, tg);
			if (op != OP_NONE) begin
				done++;
				if (done == stall_at)
					stall_rx = 1'b1;
			end
		end
	endtask

	initial begin
		int i;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part
		send_item(OP_TICK, 32'd0, 16'd0);
		send_item(OP_NONE, 32'hFFFF_FFFF, 16'hFFFF);
		send_item(OP_CANCEL, 32'd0, 16'h1234);
		send_item(OP_INSERT, 32'd0, 16'h0000);
		send_item(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
		send_item(OP_INSERT, 32'd2, 16'h0001);
		send_item(OP_INSERT, 32'd2, 16'h0002);
		send_item(OP_INSERT, 32'd2, 16'h0001);
		send_item(OP_INSERT, 32'd1, 16'h0001);
		send_item(OP_CANCEL, 32'd0, 16'h0001);
		send_item(OP_CANCEL, 32'd0, 16'hABCD);
		send_item(OP_TICK, 32'd0, 16'd0);
		send_item(OP_TICK, 32'd0, 16'd0);
		wait_drained();
		send_item(OP_CANCEL, 32'd0, 16'hFFFF);
		for (i = 0; i < QUEUE_DEPTH; i++)
			send_item(OP_INSERT, 32'd0, 16'(i * 16'h1111 + 16'h0100));
		send_item(OP_INSERT, 32'd5, 16'h5555);
		send_item(OP_TICK, 32'd0, 16'd0);
		wait_drained();

		run_random(120, 60);
		wait_drained();
		tx_idle_pct = 84;
		rx_idle_pct = 30;
		run_random(120, -1);
		wait_drained();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_random(130, 50);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
